// ----- rtl/core/hsl2rgb_pkg.sv -----
package hsl2rgb_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int IN_W          = 13;
  localparam int CH_W          = 8;
  localparam int ERR_W         = 2;
  localparam int SECT_W        = 3;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_HUE   = 2'd1,
    ERR_SAT   = 2'd2,
    ERR_LIGHT = 2'd3
  } err_e;

  // hue sector, one per sixth of a turn, plus SECT_FULL for a full turn
  typedef enum logic [SECT_W-1:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYN  = 3'd2,
    SECT_CYN_BLU  = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5,
    SECT_FULL     = 3'd6
  } sector_e;

endpackage

// ----- rtl/core/hsl2rgb_prep.sv -----
module hsl2rgb_prep #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]      hue_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]      saturation_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]      lightness_i,
  output hsl2rgb_pkg::err_e                 err_o,
  output hsl2rgb_pkg::sector_e              sector_o,
  output logic [FRAC_BITS-2:0]              t_o,
  output logic [FRAC_BITS:0]                a_o,
  output logic [FRAC_BITS:0]                s_o,
  output logic [FRAC_BITS:0]                l_o
);

  localparam int CW = ((FRAC_BITS + 3 > hsl2rgb_pkg::IN_W) ?
                       FRAC_BITS + 3 : hsl2rgb_pkg::IN_W) + 1;
  localparam int VW = FRAC_BITS + 1;
  localparam logic [CW-1:0]        HUE_MAX = CW'(6 * (1 << (FRAC_BITS - 2)));
  localparam logic [CW-1:0]        ONE_C   = CW'(1 << FRAC_BITS);
  localparam logic [VW:0]          ONE_W   = (VW + 1)'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS-1:0] SEC_F   = FRAC_BITS'(1 << (FRAC_BITS - 2));
  localparam logic [FRAC_BITS-1:0] SEC2_F  = FRAC_BITS'(1 << (FRAC_BITS - 1));

  logic [CW-1:0]                   h_ext, s_ext, l_ext;
  logic [VW:0]                     twol, dev;
  logic [FRAC_BITS-1:0]            hm, t_full;
  logic [hsl2rgb_pkg::SECT_W-1:0]  sect_raw;
  hsl2rgb_pkg::err_e               err_d;
  hsl2rgb_pkg::sector_e            sector_d;
  logic [VW-1:0]                   a_d;

  always_comb begin
    h_ext = CW'(hue_i);
    s_ext = CW'(saturation_i);
    l_ext = CW'(lightness_i);

    if (h_ext > HUE_MAX) begin
      err_d = hsl2rgb_pkg::ERR_HUE;
    end else if (s_ext > ONE_C) begin
      err_d = hsl2rgb_pkg::ERR_SAT;
    end else if (l_ext > ONE_C) begin
      err_d = hsl2rgb_pkg::ERR_LIGHT;
    end else begin
      err_d = hsl2rgb_pkg::ERR_NONE;
    end

    // 1 - |2L - 1|
    twol = {l_ext[VW-1:0], 1'b0};
    dev  = (twol >= ONE_W) ? (twol - ONE_W) : (ONE_W - twol);
    a_d  = VW'(ONE_W - dev);

    // a full turn wraps to the first sector
    sect_raw = hsl2rgb_pkg::SECT_W'(h_ext >> (FRAC_BITS - 2));
    if (sect_raw == hsl2rgb_pkg::SECT_FULL) begin
      sector_d = hsl2rgb_pkg::SECT_RED_YEL;
    end else begin
      sector_d = hsl2rgb_pkg::sector_e'(sect_raw);
    end

    // distance of the hue from the nearest even sector boundary
    hm     = {1'b0, h_ext[FRAC_BITS-2:0]};
    t_full = (hm >= SEC_F) ? (SEC2_F - hm) : hm;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_o    <= err_d;
      sector_o <= sector_d;
      t_o      <= t_full[FRAC_BITS-2:0];
      a_o      <= a_d;
      s_o      <= s_ext[VW-1:0];
      l_o      <= l_ext[VW-1:0];
    end
  end

endmodule

// ----- rtl/core/hsl2rgb_chroma.sv -----
module hsl2rgb_chroma #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,
  input  hsl2rgb_pkg::err_e             err_i,
  input  hsl2rgb_pkg::sector_e          sector_i,
  input  logic [FRAC_BITS-2:0]          t_i,
  input  logic [FRAC_BITS:0]            a_i,
  input  logic [FRAC_BITS:0]            s_i,
  input  logic [FRAC_BITS:0]            l_i,
  output hsl2rgb_pkg::err_e             err_o,
  output hsl2rgb_pkg::sector_e          sector_o,
  output logic [2*FRAC_BITS+2:0]        hi_n_o,
  output logic [2*FRAC_BITS+1:0]        lo_n_o,
  output logic [3*FRAC_BITS-1:0]        xp_o
);

  localparam int VW  = FRAC_BITS + 1;
  localparam int AW  = 2 * FRAC_BITS + 1;
  localparam int TW  = FRAC_BITS - 1;
  localparam int LOW = 2 * FRAC_BITS + 2;
  localparam int HW  = 2 * FRAC_BITS + 3;

  // stage 2: chroma = a * s, scale ONE^2
  logic [2*VW-1:0]        as_full;
  logic [AW-1:0]          as_q;
  hsl2rgb_pkg::err_e      err2_q;
  hsl2rgb_pkg::sector_e   sector2_q;
  logic [TW-1:0]          t2_q;
  logic [VW-1:0]          l2_q;

  assign as_full = a_i * s_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      as_q      <= as_full[AW-1:0];
      err2_q    <= err_i;
      sector2_q <= sector_i;
      t2_q      <= t_i;
      l2_q      <= l_i;
    end
  end

  // stage 3: 2L*ONE +/- chroma, and chroma * t for the middle channel
  logic [LOW-1:0]         p2l;
  logic [HW-1:0]          hi_n_d;
  logic [LOW-1:0]         lo_n_d;
  logic [AW+TW-1:0]       xp_d;

  always_comb begin
    p2l    = {l2_q, {VW{1'b0}}};
    hi_n_d = HW'(p2l) + HW'(as_q);
    lo_n_d = p2l - LOW'(as_q);
    xp_d   = as_q * t2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      err_o    <= err2_q;
      sector_o <= sector2_q;
      hi_n_o   <= hi_n_d;
      lo_n_o   <= lo_n_d;
      xp_o     <= xp_d;
    end
  end

endmodule

// ----- rtl/core/hsl2rgb_scale.sv -----
module hsl2rgb_scale #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  hsl2rgb_pkg::err_e                 err_i,
  input  hsl2rgb_pkg::sector_e              sector_i,
  input  logic [2*FRAC_BITS+2:0]            hi_n_i,
  input  logic [2*FRAC_BITS+1:0]            lo_n_i,
  input  logic [3*FRAC_BITS-1:0]            xp_i,
  output logic [hsl2rgb_pkg::CH_W-1:0]      red_o,
  output logic [hsl2rgb_pkg::CH_W-1:0]      green_o,
  output logic [hsl2rgb_pkg::CH_W-1:0]      blue_o,
  output logic [hsl2rgb_pkg::ERR_W-1:0]     error_code_o
);

  localparam int CW  = hsl2rgb_pkg::CH_W;
  localparam int LOW = 2 * FRAC_BITS + 2;
  localparam int HW  = 2 * FRAC_BITS + 3;
  localparam int PW  = 3 * FRAC_BITS;
  localparam int MW  = 3 * FRAC_BITS + 2;

  // stage 4: scale outer channels by 255, build middle numerator
  logic [HW+CW-1:0]       hi_x;
  logic [LOW+CW-1:0]      lo_x;
  logic [MW-1:0]          mid_n_d;
  logic [CW-1:0]          hi_b_q, lo_b_q;
  logic [MW-1:0]          mid_n_q;
  hsl2rgb_pkg::err_e      err4_q;
  hsl2rgb_pkg::sector_e   sector4_q;

  always_comb begin
    hi_x    = {hi_n_i, {CW{1'b0}}} - (HW + CW)'(hi_n_i);
    lo_x    = {lo_n_i, {CW{1'b0}}} - (LOW + CW)'(lo_n_i);
    mid_n_d = MW'({xp_i, 1'b0}) + MW'({lo_n_i, {(FRAC_BITS - 2){1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hi_b_q    <= hi_x[2*FRAC_BITS+1 +: CW];
      lo_b_q    <= lo_x[2*FRAC_BITS+1 +: CW];
      mid_n_q   <= mid_n_d;
      err4_q    <= err_i;
      sector4_q <= sector_i;
    end
  end

  // stage 5: middle channel, sector permutation, error blanking
  logic [MW+CW-1:0]       mid_x;
  logic [CW-1:0]          mid_b;
  logic [CW-1:0]          r_d, g_d, b_d;

  always_comb begin
    mid_x = {mid_n_q, {CW{1'b0}}} - (MW + CW)'(mid_n_q);
    mid_b = mid_x[PW-1 +: CW];
    case (sector4_q)
      hsl2rgb_pkg::SECT_RED_YEL: begin
        r_d = hi_b_q;  g_d = mid_b;  b_d = lo_b_q;
      end
      hsl2rgb_pkg::SECT_YEL_GRN: begin
        r_d = mid_b;   g_d = hi_b_q; b_d = lo_b_q;
      end
      hsl2rgb_pkg::SECT_GRN_CYN: begin
        r_d = lo_b_q;  g_d = hi_b_q; b_d = mid_b;
      end
      hsl2rgb_pkg::SECT_CYN_BLU: begin
        r_d = lo_b_q;  g_d = mid_b;  b_d = hi_b_q;
      end
      hsl2rgb_pkg::SECT_BLU_MAG: begin
        r_d = mid_b;   g_d = lo_b_q; b_d = hi_b_q;
      end
      default: begin
        r_d = hi_b_q;  g_d = lo_b_q; b_d = mid_b;
      end
    endcase
    if (err4_q != hsl2rgb_pkg::ERR_NONE) begin
      r_d = '0;
      g_d = '0;
      b_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      red_o        <= r_d;
      green_o      <= g_d;
      blue_o       <= b_d;
      error_code_o <= err4_q;
    end
  end

endmodule

// ----- rtl/core/hsl_to_rgb_converter.sv -----
// channel   direction  handshake                     payload
// input     in         in_valid_i / in_ready_o       hue_i, saturation_i, lightness_i
// output    out        out_valid_o / out_ready_i     red_o, green_o, blue_o, error_code_o
//
// five register stages: decode, chroma multiply, hue multiply, scale, permute
// one pixel per cycle sustained while the output is ready
// reset clears only the stage valid bits; the data registers are not reset
// each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stalled output holds everything behind it with nothing lost
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [hsl2rgb_pkg::IN_W-1:0]      hue_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]      saturation_i,
  input  logic [hsl2rgb_pkg::IN_W-1:0]      lightness_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hsl2rgb_pkg::CH_W-1:0]      red_o,
  output logic [hsl2rgb_pkg::CH_W-1:0]      green_o,
  output logic [hsl2rgb_pkg::CH_W-1:0]      blue_o,
  output logic [hsl2rgb_pkg::ERR_W-1:0]     error_code_o
);

  localparam int NSTG = 5;

  logic [NSTG-1:0]  valid_q, valid_d;
  logic [NSTG-1:0]  en;

  always_comb begin
    en[NSTG-1] = ~valid_q[NSTG-1] | out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NSTG-1];

  hsl2rgb_pkg::err_e      err1, err3;
  hsl2rgb_pkg::sector_e   sector1, sector3;
  logic [FRAC_BITS-2:0]   t1;
  logic [FRAC_BITS:0]     a1, s1, l1;
  logic [2*FRAC_BITS+2:0] hi_n3;
  logic [2*FRAC_BITS+1:0] lo_n3;
  logic [3*FRAC_BITS-1:0] xp3;

  hsl2rgb_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .en_i        (en[0]),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .err_o       (err1),
    .sector_o    (sector1),
    .t_o         (t1),
    .a_o         (a1),
    .s_o         (s1),
    .l_o         (l1)
  );

  hsl2rgb_chroma #(
    .FRAC_BITS(FRAC_BITS)
  ) u_chroma (
    .clk_i   (clk_i),
    .en_i    (en[2:1]),
    .err_i   (err1),
    .sector_i(sector1),
    .t_i     (t1),
    .a_i     (a1),
    .s_i     (s1),
    .l_i     (l1),
    .err_o   (err3),
    .sector_o(sector3),
    .hi_n_o  (hi_n3),
    .lo_n_o  (lo_n3),
    .xp_o    (xp3)
  );

  hsl2rgb_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .en_i        (en[4:3]),
    .err_i       (err3),
    .sector_i    (sector3),
    .hi_n_i      (hi_n3),
    .lo_n_i      (lo_n3),
    .xp_i        (xp3),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .error_code_o(error_code_o)
  );

`ifndef SYNTHESIS
  // a rejected pixel always leaves as black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != hsl2rgb_pkg::ERR_NONE) |->
      (red_o == '0) && (green_o == '0) && (blue_o == '0))
    else $error("error transaction carries nonzero colour");

  // input backpressure only when the whole pipe is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q == {NSTG{1'b1}}) && !out_ready_i)
    else $error("input stalled while pipeline has room");

  // a held stage keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && !en[3] |=> valid_q[3])
    else $error("held transaction dropped in scale stage");
`endif

endmodule
